### hdl/dfr_pkg.sv
// Shared types, constants and tables for the dual-fisheye source-position generator.
// No dependencies; every other file of the block refers to this package by scoped name.
`timescale 1ns / 1ps

package dfr_pkg;

    localparam int FRACTION_BITS_DEF = 5;
    localparam int SQRT_STEPS        = 31;
    localparam int CORDIC_STEPS      = 24;
    localparam int QUOT_BITS         = 25;

    typedef logic [2:0] cfg_idx_t;

    localparam cfg_idx_t REG_RAY_X    = 3'd0;
    localparam cfg_idx_t REG_RAY_Y    = 3'd1;
    localparam cfg_idx_t REG_RAY_W    = 3'd2;
    localparam cfg_idx_t REG_FOCAL    = 3'd3;
    localparam cfg_idx_t REG_FRONT_CX = 3'd4;
    localparam cfg_idx_t REG_BACK_CX  = 3'd5;
    localparam cfg_idx_t REG_CENTER_Y = 3'd6;

    typedef struct packed {
        logic [10:0] pixel_row;
        logic [10:0] pixel_col;
    } in_word_t;

    typedef struct packed {
        logic signed [15:0] source_x_int;
        logic signed [15:0] source_y_int;
        logic [9:0]         fraction_index;
        logic               clipped;
    } out_word_t;

    // Carried alongside the square root.
    typedef struct packed {
        logic [29:0] mx;
        logic [29:0] my;
        logic [29:0] mw;
        logic        sx;
        logic        sy;
        logic        front;
        logic        kill;
    } sq_side_t;

    // Carried alongside the CORDIC.
    typedef struct packed {
        logic [29:0] mx;
        logic [29:0] my;
        logic [30:0] r;
        logic        sx;
        logic        sy;
        logic        front;
        logic        kill;
    } cd_side_t;

    // Carried alongside the divider.
    typedef struct packed {
        logic sx;
        logic sy;
        logic front;
        logic kill;
    } dv_side_t;

    // Arc tangent of 2^-i in units of 2^-24 rad.
    function automatic logic [24:0] arc_at(input int i);
        logic [24:0] a;
        case (i)
            0:       a = 25'd13176795;
            1:       a = 25'd7778716;
            2:       a = 25'd4110060;
            3:       a = 25'd2086331;
            4:       a = 25'd1047214;
            5:       a = 25'd524117;
            6:       a = 25'd262123;
            7:       a = 25'd131069;
            8:       a = 25'd65536;
            9:       a = 25'd32768;
            10:      a = 25'd16384;
            11:      a = 25'd8192;
            12:      a = 25'd4096;
            13:      a = 25'd2048;
            14:      a = 25'd1024;
            15:      a = 25'd512;
            16:      a = 25'd256;
            17:      a = 25'd128;
            18:      a = 25'd64;
            19:      a = 25'd32;
            20:      a = 25'd16;
            21:      a = 25'd8;
            22:      a = 25'd4;
            23:      a = 25'd2;
            default: a = 25'd0;
        endcase
        return a;
    endfunction

endpackage

### hdl/dual_fisheye_remap_map_gen.sv
// Top level of the dual-fisheye source-position generator: configuration registers,
// the pipeline enable and the chain of stages. Depends on dfr_pkg and all dfr_ modules.
`timescale 1ns / 1ps

//  channel   direction  handshake           word
//  in        into       in_valid/in_stall   dfr_pkg::in_word_t  (pixel_row, pixel_col)
//  out       out of     out_valid/out_stall dfr_pkg::out_word_t (x, y, fraction, clipped)
//  cfg       into       cfg_en              cfg_index, cfg_data
//
// One word enters per clock while in_stall is low; the depth is set by the 31-stage square root,
// the 24-stage CORDIC and the 25 quotient-bit stages of the divider plus nine stages around them.
// Reset clears every valid bit and loads the configuration defaults.
// The whole pipeline holds while the output register is full and stalled, so
// in_stall follows out_valid and out_stall in the same cycle.

module dual_fisheye_remap_map_gen #(
    parameter int FRACTION_BITS = dfr_pkg::FRACTION_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  dfr_pkg::in_word_t   in_word,
    output logic                out_valid,
    input  logic                out_stall,
    output dfr_pkg::out_word_t  out_word,
    input  logic                cfg_en,
    input  dfr_pkg::cfg_idx_t   cfg_index,
    input  logic [62:0]         cfg_data
);

    logic [62:0] ray_x_reg, ray_y_reg, ray_w_reg;
    logic [15:0] focal_reg;
    logic [11:0] front_cx_reg, back_cx_reg, center_y_reg;

    logic pipe_en;

    logic               f_valid;
    logic [60:0]        f_norm;
    dfr_pkg::sq_side_t  f_side;
    logic               s_valid;
    logic [30:0]        s_root;
    dfr_pkg::sq_side_t  s_side;
    logic               c_valid;
    logic [24:0]        c_theta;
    dfr_pkg::cd_side_t  c_side;
    logic               d_valid;
    logic [24:0]        d_qx, d_qy;
    dfr_pkg::dv_side_t  d_side;

    assign pipe_en  = !(out_valid && out_stall);
    assign in_stall = !pipe_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ray_x_reg    <= 63'd262144;
            ray_y_reg    <= 63'd549755813888;
            ray_w_reg    <= 63'd1152921504606846976;
            focal_reg    <= 16'd11584;
            front_cx_reg <= 12'd320;
            back_cx_reg  <= 12'd958;
            center_y_reg <= 12'd320;
        end
        else if (cfg_en)
        begin
            case (cfg_index)
                dfr_pkg::REG_RAY_X:    ray_x_reg    <= cfg_data;
                dfr_pkg::REG_RAY_Y:    ray_y_reg    <= cfg_data;
                dfr_pkg::REG_RAY_W:    ray_w_reg    <= cfg_data;
                dfr_pkg::REG_FOCAL:    focal_reg    <= cfg_data[15:0];
                dfr_pkg::REG_FRONT_CX: front_cx_reg <= cfg_data[11:0];
                dfr_pkg::REG_BACK_CX:  back_cx_reg  <= cfg_data[11:0];
                dfr_pkg::REG_CENTER_Y: center_y_reg <= cfg_data[11:0];
                default: ;
            endcase
        end
    end

    dfr_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (pipe_en),
        .in_valid     (in_valid),
        .in_word      (in_word),
        .ray_x_coeffs (ray_x_reg),
        .ray_y_coeffs (ray_y_reg),
        .ray_w_coeffs (ray_w_reg),
        .out_valid    (f_valid),
        .norm_sq      (f_norm),
        .side         (f_side)
    );

    dfr_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (f_valid),
        .radicand  (f_norm),
        .in_side   (f_side),
        .out_valid (s_valid),
        .root      (s_root),
        .out_side  (s_side)
    );

    dfr_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (s_valid),
        .root      (s_root),
        .in_side   (s_side),
        .out_valid (c_valid),
        .theta     (c_theta),
        .out_side  (c_side)
    );

    dfr_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (c_valid),
        .theta     (c_theta),
        .in_side   (c_side),
        .out_valid (d_valid),
        .quot_x    (d_qx),
        .quot_y    (d_qy),
        .out_side  (d_side)
    );

    dfr_place #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_place (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (pipe_en),
        .in_valid       (d_valid),
        .quot_x         (d_qx),
        .quot_y         (d_qy),
        .in_side        (d_side),
        .focal_length   (focal_reg),
        .front_center_x (front_cx_reg),
        .back_center_x  (back_cx_reg),
        .lens_center_y  (center_y_reg),
        .out_valid      (out_valid),
        .out_word       (out_word)
    );

    // A saturated word carries a coordinate at one end of the 16-bit range.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.clipped |->
            out_word.source_x_int == 16'sh7FFF || out_word.source_x_int == -16'sh8000 ||
            out_word.source_y_int == 16'sh7FFF || out_word.source_y_int == -16'sh8000)
        else $error("clipped set without a saturated coordinate");

    // A new word can appear at the output only after the pipeline moved.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(pipe_en))
        else $error("output word appeared while the pipeline was held");

    // While the output is held, nothing is taken in.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("input taken while the output was stalled");

endmodule

### hdl/dfr_front.sv
// Ray formation, magnitude normalisation and squared norm, five register stages.
// Depends on dfr_pkg for the input word and the square-root side band.
`timescale 1ns / 1ps

module dfr_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  dfr_pkg::in_word_t   in_word,
    input  logic [62:0]         ray_x_coeffs,
    input  logic [62:0]         ray_y_coeffs,
    input  logic [62:0]         ray_w_coeffs,
    output logic                out_valid,
    output logic [60:0]         norm_sq,
    output dfr_pkg::sq_side_t   side
);

    logic [4:0] valid_reg;

    // Stage 0: products.
    logic signed [32:0] pcx_reg, prx_reg, pcy_reg, pry_reg, pcw_reg, prw_reg;
    logic signed [20:0] kx_reg, ky_reg, kw_reg;
    // Stage 1: ray components.
    logic signed [33:0] rx_reg, ry_reg, rw_reg;
    // Stage 2: normalised magnitudes.
    logic [29:0] mx_reg, my_reg, mw_reg;
    logic        sx_reg, sy_reg, front_reg, kill_reg;
    // Stage 3: squares.
    logic [59:0] sqx_reg, sqy_reg;
    dfr_pkg::sq_side_t s3_reg;
    // Stage 4: sum.
    logic [60:0] norm_reg;
    dfr_pkg::sq_side_t s4_reg;

    logic signed [11:0] col_s, row_s;
    logic [33:0] ax, ay, aw, aor;
    logic [2:0]  shamt;

    assign col_s = $signed({1'b0, in_word.pixel_col});
    assign row_s = $signed({1'b0, in_word.pixel_row});

    always_comb
    begin
        ax  = rx_reg[33] ? 34'(-rx_reg) : 34'(rx_reg);
        ay  = ry_reg[33] ? 34'(-ry_reg) : 34'(ry_reg);
        aw  = rw_reg[33] ? 34'(-rw_reg) : 34'(rw_reg);
        aor = ax | ay | aw;
        // Smallest common shift that brings all three below 2^30.
        if (aor[33])
        begin
            shamt = 3'd4;
        end
        else if (aor[32])
        begin
            shamt = 3'd3;
        end
        else if (aor[31])
        begin
            shamt = 3'd2;
        end
        else if (aor[30])
        begin
            shamt = 3'd1;
        end
        else
        begin
            shamt = 3'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pcx_reg <= col_s * $signed(ray_x_coeffs[20:0]);
            prx_reg <= row_s * $signed(ray_x_coeffs[41:21]);
            pcy_reg <= col_s * $signed(ray_y_coeffs[20:0]);
            pry_reg <= row_s * $signed(ray_y_coeffs[41:21]);
            pcw_reg <= col_s * $signed(ray_w_coeffs[20:0]);
            prw_reg <= row_s * $signed(ray_w_coeffs[41:21]);
            kx_reg  <= $signed(ray_x_coeffs[62:42]);
            ky_reg  <= $signed(ray_y_coeffs[62:42]);
            kw_reg  <= $signed(ray_w_coeffs[62:42]);

            rx_reg <= 34'(pcx_reg) + 34'(prx_reg) + 34'(kx_reg);
            ry_reg <= 34'(pcy_reg) + 34'(pry_reg) + 34'(ky_reg);
            rw_reg <= 34'(pcw_reg) + 34'(prw_reg) + 34'(kw_reg);

            mx_reg    <= 30'(ax >> shamt);
            my_reg    <= 30'(ay >> shamt);
            mw_reg    <= 30'(aw >> shamt);
            sx_reg    <= rx_reg[33];
            sy_reg    <= ry_reg[33];
            front_reg <= !rw_reg[33] && (rw_reg != '0);
            kill_reg  <= (rw_reg == '0);

            sqx_reg         <= mx_reg * mx_reg;
            sqy_reg         <= my_reg * my_reg;
            s3_reg.mx       <= mx_reg;
            s3_reg.my       <= my_reg;
            s3_reg.mw       <= mw_reg;
            s3_reg.sx       <= sx_reg;
            s3_reg.sy       <= sy_reg;
            s3_reg.front    <= front_reg;
            s3_reg.kill     <= kill_reg;

            norm_reg <= 61'(sqx_reg) + 61'(sqy_reg);
            s4_reg   <= s3_reg;
        end
    end

    assign out_valid = valid_reg[4];
    assign norm_sq   = norm_reg;
    assign side      = s4_reg;

endmodule

### hdl/dfr_sqrt.sv
// Pipelined floor square root, one result bit per register stage.
// Depends on dfr_pkg for the side band carried with each word.
`timescale 1ns / 1ps

module dfr_sqrt (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [60:0]         radicand,
    input  dfr_pkg::sq_side_t   in_side,
    output logic                out_valid,
    output logic [30:0]         root,
    output dfr_pkg::sq_side_t   out_side
);

    localparam int N = dfr_pkg::SQRT_STEPS;

    logic [N-1:0]      valid_reg;
    logic [32:0]       rem_reg   [0:N-1];
    logic [32:0]       rem_next  [0:N-1];
    logic [30:0]       root_reg  [0:N-1];
    logic [30:0]       root_next [0:N-1];
    logic [61:0]       v_reg     [0:N-1];
    logic [61:0]       v_next    [0:N-1];
    dfr_pkg::sq_side_t side_reg  [0:N-1];

    // Each stage brings down two radicand bits and tries the next root bit.
    always_comb
    begin
        for (int k = 0; k < N; k++)
        begin
            logic [32:0] prem;
            logic [30:0] proot;
            logic [61:0] pv;
            logic [34:0] cur;
            logic [34:0] trial;
            if (k == 0)
            begin
                prem  = '0;
                proot = '0;
                pv    = {1'b0, radicand};
            end
            else
            begin
                prem  = rem_reg[k-1];
                proot = root_reg[k-1];
                pv    = v_reg[k-1];
            end
            cur   = {prem, pv[61:60]};
            trial = {2'b00, proot, 2'b01};
            if (cur >= trial)
            begin
                rem_next[k]  = 33'(cur - trial);
                root_next[k] = {proot[29:0], 1'b1};
            end
            else
            begin
                rem_next[k]  = cur[32:0];
                root_next[k] = {proot[29:0], 1'b0};
            end
            v_next[k] = {pv[59:0], 2'b00};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[N-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < N; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                v_reg[k]    <= v_next[k];
                side_reg[k] <= (k == 0) ? in_side : side_reg[(k == 0) ? 0 : k-1];
            end
        end
    end

    assign out_valid = valid_reg[N-1];
    assign root      = root_reg[N-1];
    assign out_side  = side_reg[N-1];

endmodule

### hdl/dfr_cordic.sv
// Pipelined CORDIC in vectoring mode: the ray angle from the axis, one rotation a stage.
// Depends on dfr_pkg for the arc table and the side bands.
`timescale 1ns / 1ps

module dfr_cordic (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [30:0]         root,
    input  dfr_pkg::sq_side_t   in_side,
    output logic                out_valid,
    output logic [24:0]         theta,
    output dfr_pkg::cd_side_t   out_side
);

    localparam int N = dfr_pkg::CORDIC_STEPS;

    logic [N-1:0]       valid_reg;
    logic signed [34:0] a_reg  [0:N-1];
    logic signed [34:0] a_next [0:N-1];
    logic signed [34:0] b_reg  [0:N-1];
    logic signed [34:0] b_next [0:N-1];
    logic signed [26:0] z_reg  [0:N-1];
    logic signed [26:0] z_next [0:N-1];
    dfr_pkg::cd_side_t  side_reg [0:N-1];
    dfr_pkg::cd_side_t  side_in;

    always_comb
    begin
        side_in.mx    = in_side.mx;
        side_in.my    = in_side.my;
        side_in.r     = root;
        side_in.sx    = in_side.sx;
        side_in.sy    = in_side.sy;
        side_in.front = in_side.front;
        side_in.kill  = in_side.kill || (root == '0);
    end

    always_comb
    begin
        for (int k = 0; k < N; k++)
        begin
            logic signed [34:0] pa;
            logic signed [34:0] pb;
            logic signed [26:0] pz;
            logic signed [26:0] arc;
            if (k == 0)
            begin
                pa = $signed(35'(in_side.mw));
                pb = $signed(35'(root));
                pz = '0;
            end
            else
            begin
                pa = a_reg[k-1];
                pb = b_reg[k-1];
                pz = z_reg[k-1];
            end
            arc = $signed(27'(dfr_pkg::arc_at(k)));
            if (!pb[34])
            begin
                a_next[k] = pa + (pb >>> k);
                b_next[k] = pb - (pa >>> k);
                z_next[k] = pz + arc;
            end
            else
            begin
                a_next[k] = pa - (pb >>> k);
                b_next[k] = pb + (pa >>> k);
                z_next[k] = pz - arc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[N-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < N; k++)
            begin
                a_reg[k]    <= a_next[k];
                b_reg[k]    <= b_next[k];
                z_reg[k]    <= z_next[k];
                side_reg[k] <= (k == 0) ? side_in : side_reg[(k == 0) ? 0 : k-1];
            end
        end
    end

    // A negative final angle clamps to zero.
    assign theta     = z_reg[N-1][26] ? '0 : z_reg[N-1][24:0];
    assign out_valid = valid_reg[N-1];
    assign out_side  = side_reg[N-1];

endmodule

### hdl/dfr_div.sv
// Scales both magnitudes by the angle and divides by the norm: two lanes sharing
// one divisor, a multiply stage then one restoring quotient bit a stage. Uses dfr_pkg.
`timescale 1ns / 1ps

module dfr_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [24:0]         theta,
    input  dfr_pkg::cd_side_t   in_side,
    output logic                out_valid,
    output logic [24:0]         quot_x,
    output logic [24:0]         quot_y,
    output dfr_pkg::dv_side_t   out_side
);

    localparam int N = dfr_pkg::QUOT_BITS;

    logic               mvalid_reg;
    logic [54:0]        nx_reg, ny_reg;
    logic [30:0]        r_reg;
    dfr_pkg::dv_side_t  mside_reg;

    logic [N-1:0]       valid_reg;
    logic [54:0]        remx_reg  [0:N-1];
    logic [54:0]        remx_next [0:N-1];
    logic [54:0]        remy_reg  [0:N-1];
    logic [54:0]        remy_next [0:N-1];
    logic [N-1:0]       qx_reg    [0:N-1];
    logic [N-1:0]       qx_next   [0:N-1];
    logic [N-1:0]       qy_reg    [0:N-1];
    logic [N-1:0]       qy_next   [0:N-1];
    logic [30:0]        d_reg     [0:N-1];
    dfr_pkg::dv_side_t  side_reg  [0:N-1];

    // The magnitude never exceeds the norm, so the quotient fits in N bits.
    always_comb
    begin
        for (int k = 0; k < N; k++)
        begin
            logic [54:0]  px;
            logic [54:0]  py;
            logic [N-1:0] pqx;
            logic [N-1:0] pqy;
            logic [30:0]  pd;
            logic [55:0]  dsh;
            if (k == 0)
            begin
                px  = nx_reg;
                py  = ny_reg;
                pqx = '0;
                pqy = '0;
                pd  = r_reg;
            end
            else
            begin
                px  = remx_reg[k-1];
                py  = remy_reg[k-1];
                pqx = qx_reg[k-1];
                pqy = qy_reg[k-1];
                pd  = d_reg[k-1];
            end
            dsh = 56'(pd) << (N - 1 - k);
            if ({1'b0, px} >= dsh)
            begin
                remx_next[k] = 55'({1'b0, px} - dsh);
                qx_next[k]   = {pqx[N-2:0], 1'b1};
            end
            else
            begin
                remx_next[k] = px;
                qx_next[k]   = {pqx[N-2:0], 1'b0};
            end
            if ({1'b0, py} >= dsh)
            begin
                remy_next[k] = 55'({1'b0, py} - dsh);
                qy_next[k]   = {pqy[N-2:0], 1'b1};
            end
            else
            begin
                remy_next[k] = py;
                qy_next[k]   = {pqy[N-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mvalid_reg <= 1'b0;
            valid_reg  <= '0;
        end
        else if (en)
        begin
            mvalid_reg <= in_valid;
            valid_reg  <= {valid_reg[N-2:0], mvalid_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nx_reg          <= in_side.mx * theta;
            ny_reg          <= in_side.my * theta;
            r_reg           <= in_side.r;
            mside_reg.sx    <= in_side.sx;
            mside_reg.sy    <= in_side.sy;
            mside_reg.front <= in_side.front;
            mside_reg.kill  <= in_side.kill;
            for (int k = 0; k < N; k++)
            begin
                remx_reg[k] <= remx_next[k];
                remy_reg[k] <= remy_next[k];
                qx_reg[k]   <= qx_next[k];
                qy_reg[k]   <= qy_next[k];
                d_reg[k]    <= (k == 0) ? r_reg : d_reg[(k == 0) ? 0 : k-1];
                side_reg[k] <= (k == 0) ? mside_reg : side_reg[(k == 0) ? 0 : k-1];
            end
        end
    end

    assign out_valid = valid_reg[N-1];
    assign quot_x    = qx_reg[N-1];
    assign quot_y    = qy_reg[N-1];
    assign out_side  = side_reg[N-1];

endmodule

### hdl/dfr_place.sv
// Lens selection, focal scaling, rounding and saturation; ends in the output register.
// Depends on dfr_pkg for the output word and the divider side band.
`timescale 1ns / 1ps

module dfr_place #(
    parameter int FRACTION_BITS = dfr_pkg::FRACTION_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [24:0]         quot_x,
    input  logic [24:0]         quot_y,
    input  dfr_pkg::dv_side_t   in_side,
    input  logic [15:0]         focal_length,
    input  logic [11:0]         front_center_x,
    input  logic [11:0]         back_center_x,
    input  logic [11:0]         lens_center_y,
    output logic                out_valid,
    output dfr_pkg::out_word_t  out_word
);

    localparam int SH = 30 - FRACTION_BITS;

    logic [2:0]         valid_reg;
    logic signed [42:0] prodx_reg, prody_reg;
    logic [11:0]        cx_reg;
    logic signed [47:0] posx_reg, posy_reg;
    dfr_pkg::out_word_t word_reg;

    logic signed [25:0] offx, offy;
    logic signed [16:0] focal_s;
    logic signed [47:0] half;
    logic signed [17:0] ipx, ipy;
    logic               clipx, clipy;
    logic [15:0]        frac_cat;

    always_comb
    begin
        // The back lens mirrors x; y takes the sign of its own ray component on both lenses.
        if (in_side.kill)
        begin
            offx = '0;
            offy = '0;
        end
        else
        begin
            offx = (in_side.sx ^ !in_side.front) ? -$signed({1'b0, quot_x})
                                                 : $signed({1'b0, quot_x});
            offy = in_side.sy ? -$signed({1'b0, quot_y}) : $signed({1'b0, quot_y});
        end
        focal_s = $signed({1'b0, focal_length});
        half    = 48'sd1 <<< (SH - 1);
        ipx     = posx_reg[47:30];
        ipy     = posy_reg[47:30];
        clipx   = (ipx > 18'sd32767) || (ipx < -18'sd32768);
        clipy   = (ipy > 18'sd32767) || (ipy < -18'sd32768);
        frac_cat = 16'({posy_reg[29:SH], posx_reg[29:SH]});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prodx_reg <= focal_s * offx;
            prody_reg <= focal_s * offy;
            cx_reg    <= in_side.front ? front_center_x : back_center_x;

            posx_reg <= $signed({6'd0, cx_reg, 30'd0}) + 48'(prodx_reg) + half;
            posy_reg <= $signed({6'd0, lens_center_y, 30'd0}) + 48'(prody_reg) + half;

            word_reg.source_x_int   <= ipx[17] ? (clipx ? -16'sd32768 : ipx[15:0])
                                               : (clipx ? 16'sd32767 : ipx[15:0]);
            word_reg.source_y_int   <= ipy[17] ? (clipy ? -16'sd32768 : ipy[15:0])
                                               : (clipy ? 16'sd32767 : ipy[15:0]);
            word_reg.fraction_index <= frac_cat[9:0];
            word_reg.clipped        <= clipx || clipy;
        end
    end

    assign out_valid = valid_reg[2];
    assign out_word  = word_reg;

endmodule
